// ===== rtl/fuzzy_path_match_scorer_defines.svh =====
// Assertion macros shared by the scorer modules.
`ifndef FUZZY_PATH_MATCH_SCORER_DEFINES_SVH
`define FUZZY_PATH_MATCH_SCORER_DEFINES_SVH

// Same-cycle implication on clk, masked while rst_n is low.
`define FPMS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication on clk, masked while rst_n is low.
`define FPMS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/fpms_pkg.sv =====
// Shared constants, types and helpers of the fuzzy path match scorer.
package fpms_pkg;

    localparam int MAX_QUERY_DEF = 16;
    localparam int MAX_PATH_DEF  = 4096;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int QLEN_W     = 5;
    localparam int SCORE_W    = 17;
    localparam int IN_TDATA_W = 8;
    localparam int OUT_TDATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_QUERY_FIRST  = 2'd0,
        REG_QUERY_SECOND = 2'd1,
        REG_QUERY_LENGTH = 2'd2
    } cfg_reg_t;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_DASH  = 8'h2D;

    localparam int SC_EXACT      = 10000;
    localparam int SC_BASE       = 100;
    localparam int SC_ADJACENT   = 50;
    localparam int SC_BOUNDARY   = 90;
    localparam int SC_START      = 20;
    localparam int SCORE_FLOOR   = -65536;
    localparam int EXACT_MIN_LEN = 3;
    localparam int LEN_DIVISOR   = 6;

    // Per-byte control flags from the greedy unit.
    typedef struct packed {
        logic take;      // byte counted (path not past the length limit)
        logic found;     // every query byte consumed, after this byte
        logic overflow;  // path ran past the length limit, after this byte
    } fpms_ctl_t;

    function automatic logic [7:0] qbyte(input logic [63:0] first,
                                         input logic [63:0] second,
                                         input logic [3:0]  k);
        logic [127:0] all;
        all = {second, first};
        return all[{k, 3'b000} +: 8];
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
    endfunction

endpackage

// ===== rtl/fuzzy_path_match_scorer.sv =====
// Top level of the fuzzy path match scorer: config, substring cell row, result stages.
//
//  channel  | dir | signals                          | item
//  ---------+-----+----------------------------------+------------------------------
//  s_axis   | in  | tvalid tready tdata[7:0] tlast   | one path byte, tlast = last
//  m_axis   | out | tvalid tready tdata[23:0]        | one score per path
//  cfg      | in  | cfg_we cfg_index[1:0] cfg_data   | register write, no wait
//
// One path byte is taken every cycle while s_axis_tready is high; the
// substring cells and the greedy matcher both update on each byte taken.
// A path's result passes the finish stage, which closes the path state, and
// the output register, which takes the score with the length term taken off
// and clamped. A stalled m_axis holds one result in the output register and
// one in the finish stage; s_axis drops tready only while both are full.
// Reset clears all path state and the query registers; no clearing pass is needed.
`include "fuzzy_path_match_scorer_defines.svh"

module fuzzy_path_match_scorer
    import fpms_pkg::*;
#(
    parameter int MAX_QUERY = MAX_QUERY_DEF,
    parameter int MAX_PATH  = MAX_PATH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // fields: path_char[7:0]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                   s_axis_tlast,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // fields: score[16:0], exact_hit[17], all_found[18], accepted[19],
    //         too_long[20], zero[23:21]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int QI_W     = $clog2(MAX_QUERY + 1);
    localparam int QX_W     = (MAX_QUERY > 1) ? $clog2(MAX_QUERY) : 1;
    localparam int POS_W    = $clog2(MAX_PATH + 1);
    localparam int Q6_W     = $clog2(MAX_PATH / LEN_DIVISOR + 1);
    localparam int RS_RAW_W = $clog2((MAX_QUERY + 1) * (MAX_PATH + 300)) + 2;
    localparam int RS_W     = (RS_RAW_W > 18) ? RS_RAW_W : 18;

    // ---------------- configuration registers ----------------
    logic [63:0]       query_first_reg;
    logic [63:0]       query_second_reg;
    logic [QLEN_W-1:0] query_length_reg;
    logic [QI_W-1:0]   qlen;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_first_reg  <= '0;
            query_second_reg <= '0;
            query_length_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_QUERY_FIRST:  query_first_reg  <= cfg_data;
                REG_QUERY_SECOND: query_second_reg <= cfg_data;
                REG_QUERY_LENGTH: query_length_reg <= cfg_data[QLEN_W-1:0];
                default:          ;
            endcase
        end
    end

    // lengths above the cell count are cut to it
    assign qlen = (query_length_reg > QLEN_W'(MAX_QUERY)) ? QI_W'(MAX_QUERY)
                                                          : QI_W'(query_length_reg);

    // ---------------- input handshake ----------------
    logic s_accept;
    logic s_last;
    logic adv;
    logic fin_valid_reg;

    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = !fin_valid_reg || adv;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign s_last        = s_axis_tlast;

    // ---------------- greedy matcher ----------------
    fpms_ctl_t              ctl;
    logic signed [RS_W-1:0] g_running;
    logic [POS_W-1:0]       g_pos;
    logic [Q6_W-1:0]        g_q6;

    fpms_greedy #(
        .MAX_QUERY (MAX_QUERY),
        .MAX_PATH  (MAX_PATH)
    ) u_greedy (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (s_accept),
        .last         (s_last),
        .ch           (s_axis_tdata[7:0]),
        .query_first  (query_first_reg),
        .query_second (query_second_reg),
        .qlen         (qlen),
        .ctl          (ctl),
        .fin_running  (g_running),
        .fin_pos      (g_pos),
        .fin_q6       (g_q6)
    );

    // ---------------- substring cell row ----------------
    // Cell k is set when query bytes 0..k end at the byte just taken; each
    // cell reads its lower neighbor's bit from the previous byte.
    logic [MAX_QUERY:0]   chain;
    logic [MAX_QUERY-1:0] cell_hit;

    assign chain[0] = 1'b1;

    for (genvar k = 0; k < MAX_QUERY; k++)
    begin : g_cell
        logic [QX_W:0] k_idx;
        logic [7:0]    qch;
        logic          chain_q;

        assign k_idx = (QX_W + 1)'(k);
        assign qch   = qbyte(query_first_reg, query_second_reg, 4'(k));

        fpms_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (ctl.take),
            .clr       (s_accept && s_last),
            .active    (QI_W'(k_idx) < qlen),
            .ch        (s_axis_tdata[7:0]),
            .qch       (qch),
            .chain_in  (k == 0 ? 1'b1 : chain[k]),
            .chain_out (chain_q),
            .hit_next  (cell_hit[k])
        );

        assign chain[k+1] = chain_q;
    end

    // exact substring seen so far in this path
    logic            exact_reg;
    logic            exact_next;
    logic [QX_W-1:0] top_sel;

    assign top_sel    = QX_W'(qlen - QI_W'(1));
    assign exact_next = exact_reg
                        || (ctl.take && (qlen >= QI_W'(EXACT_MIN_LEN)) && cell_hit[top_sel]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exact_reg <= 1'b0;
        end
        else if (s_accept && s_last)
        begin
            exact_reg <= 1'b0;
        end
        else
        begin
            exact_reg <= exact_next;
        end
    end

    // ---------------- finish stage: path state at its last byte ----------------
    logic                   fin_exact_reg;
    logic                   fin_found_reg;
    logic                   fin_over_reg;
    logic signed [RS_W-1:0] fin_running_reg;
    logic [POS_W-1:0]       fin_pos_reg;
    logic [Q6_W-1:0]        fin_q6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= 1'b0;
        end
        else if (s_accept && s_last)
        begin
            fin_valid_reg <= 1'b1;
        end
        else if (adv)
        begin
            fin_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept && s_last)
        begin
            fin_exact_reg   <= exact_next;
            fin_found_reg   <= ctl.found;
            fin_over_reg    <= ctl.overflow;
            fin_running_reg <= g_running;
            fin_pos_reg     <= g_pos;
            fin_q6_reg      <= g_q6;
        end
    end

    // ---------------- score stage ----------------
    logic signed [RS_W-1:0]    raw_score;
    logic signed [RS_W-1:0]    clamped;
    logic signed [SCORE_W-1:0] score;
    logic [OUT_TDATA_W-1:0]    out_next;
    logic [OUT_TDATA_W-1:0]    out_data_reg;
    logic                      out_valid_reg;

    always_comb
    begin
        if (fin_exact_reg)
        begin
            raw_score = RS_W'(SC_EXACT) - RS_W'(fin_pos_reg);
        end
        else if (fin_found_reg)
        begin
            raw_score = fin_running_reg - RS_W'(fin_q6_reg);
        end
        else
        begin
            raw_score = '0;
        end
        clamped  = (raw_score < RS_W'(SCORE_FLOOR)) ? RS_W'(SCORE_FLOOR) : raw_score;
        score    = SCORE_W'(clamped);
        out_next = {3'b000, fin_over_reg, (clamped > 0), fin_found_reg, fin_exact_reg,
                    score};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= fin_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && fin_valid_reg)
        begin
            out_data_reg <= out_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    `FPMS_ASSERT_NOW(a_no_overwrite, fin_valid_reg && !adv, !s_axis_tready,
        "finish stage would be overwritten")
    `FPMS_ASSERT_NEXT(a_fin_loaded, s_accept && s_last, fin_valid_reg,
        "last byte did not load finish stage")
    `FPMS_ASSERT_NEXT(a_exact_clear, s_accept && s_last, !exact_reg,
        "exact flag not cleared after last byte")

endmodule

// ===== rtl/fpms_cell.sv =====
// One substring cell: holds "query prefix up to here ends at the last byte".
module fpms_cell
    import fpms_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic       clr,
    input  logic       active,
    input  logic [7:0] ch,
    input  logic [7:0] qch,
    input  logic       chain_in,
    output logic       chain_out,
    output logic       hit_next
);

    logic match_reg;

    assign hit_next  = active && chain_in && (ch == qch);
    assign chain_out = match_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else if (clr)
        begin
            match_reg <= 1'b0;
        end
        else if (en)
        begin
            match_reg <= hit_next;
        end
    end

endmodule

// ===== rtl/fpms_greedy.sv =====
// Greedy in-order matcher, score accumulator and path counters.
`include "fuzzy_path_match_scorer_defines.svh"

module fpms_greedy
    import fpms_pkg::*;
#(
    parameter int MAX_QUERY = MAX_QUERY_DEF,
    parameter int MAX_PATH  = MAX_PATH_DEF,
    localparam int QI_W     = $clog2(MAX_QUERY + 1),
    localparam int POS_W    = $clog2(MAX_PATH + 1),
    localparam int Q6_W     = $clog2(MAX_PATH / LEN_DIVISOR + 1),
    localparam int RS_RAW_W = $clog2((MAX_QUERY + 1) * (MAX_PATH + 300)) + 2,
    localparam int RS_W     = (RS_RAW_W > 18) ? RS_RAW_W : 18
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic                   last,
    input  logic [7:0]             ch,
    input  logic [63:0]            query_first,
    input  logic [63:0]            query_second,
    input  logic [QI_W-1:0]        qlen,
    output fpms_ctl_t              ctl,
    output logic signed [RS_W-1:0] fin_running,
    output logic [POS_W-1:0]       fin_pos,
    output logic [Q6_W-1:0]        fin_q6
);

    localparam int LM_W = $clog2(MAX_PATH);

    logic [POS_W-1:0]       pos_reg,     pos_next;
    logic [2:0]             r6_reg,      r6_next;
    logic [Q6_W-1:0]        q6_reg,      q6_next;
    logic [QI_W-1:0]        qi_reg,      qi_next;
    logic [LM_W-1:0]        lastm_reg,   lastm_next;
    logic                   any_reg,     any_next;
    logic signed [RS_W-1:0] running_reg, running_next;
    logic [7:0]             prev_reg,    prev_next;
    logic                   over_reg,    over_next;

    logic                   take;
    logic                   skip;
    logic                   hit;
    logic [QI_W-1:0]        qi_skip;
    logic [7:0]             q_cur;
    logic [7:0]             q_cmp;
    logic signed [RS_W-1:0] add_v;
    logic                   at_start;
    logic                   boundary;
    logic                   adjacent;

    always_comb
    begin
        take     = accept && (pos_reg != POS_W'(MAX_PATH));
        q_cur    = qbyte(query_first, query_second, 4'(qi_reg));
        skip     = (qi_reg < qlen) && (q_cur == CH_SPACE);
        qi_skip  = qi_reg + QI_W'(skip);
        q_cmp    = qbyte(query_first, query_second, 4'(qi_skip));
        hit      = take && (qi_reg < qlen) && (qi_skip < qlen)
                   && (to_lower(ch) == to_lower(q_cmp));

        at_start = (pos_reg == '0);
        boundary = at_start || (prev_reg == CH_SLASH) || (prev_reg == CH_UNDER)
                   || (prev_reg == CH_DASH);
        adjacent = any_reg && (pos_reg == POS_W'(lastm_reg) + POS_W'(1));

        add_v = RS_W'(SC_BASE) - RS_W'(pos_reg);
        if (adjacent)
        begin
            add_v = add_v + RS_W'(SC_ADJACENT);
        end
        if (boundary)
        begin
            add_v = add_v + RS_W'(SC_BOUNDARY);
        end
        if (at_start)
        begin
            add_v = add_v + RS_W'(SC_START);
        end

        pos_next     = pos_reg;
        r6_next      = r6_reg;
        q6_next      = q6_reg;
        qi_next      = qi_reg;
        lastm_next   = lastm_reg;
        any_next     = any_reg;
        running_next = running_reg;
        prev_next    = prev_reg;
        over_next    = over_reg || (accept && !take);

        if (take)
        begin
            pos_next  = pos_reg + POS_W'(1);
            prev_next = ch;
            qi_next   = qi_skip + QI_W'(hit);
            if (r6_reg == 3'(LEN_DIVISOR - 1))
            begin
                r6_next = '0;
                q6_next = q6_reg + Q6_W'(1);
            end
            else
            begin
                r6_next = r6_reg + 3'd1;
            end
        end
        if (hit)
        begin
            running_next = running_reg + add_v;
            lastm_next   = LM_W'(pos_reg);
            any_next     = 1'b1;
        end
    end

    assign ctl.take     = take;
    assign ctl.found    = (qi_next >= qlen);
    assign ctl.overflow = over_next;
    assign fin_running  = running_next;
    assign fin_pos      = pos_next;
    assign fin_q6       = q6_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            r6_reg      <= '0;
            q6_reg      <= '0;
            qi_reg      <= '0;
            lastm_reg   <= '0;
            any_reg     <= 1'b0;
            running_reg <= '0;
            prev_reg    <= '0;
            over_reg    <= 1'b0;
        end
        else if (accept && last)
        begin
            pos_reg     <= '0;
            r6_reg      <= '0;
            q6_reg      <= '0;
            qi_reg      <= '0;
            lastm_reg   <= '0;
            any_reg     <= 1'b0;
            running_reg <= '0;
            prev_reg    <= '0;
            over_reg    <= 1'b0;
        end
        else
        begin
            pos_reg     <= pos_next;
            r6_reg      <= r6_next;
            q6_reg      <= q6_next;
            qi_reg      <= qi_next;
            lastm_reg   <= lastm_next;
            any_reg     <= any_next;
            running_reg <= running_next;
            prev_reg    <= prev_next;
            over_reg    <= over_next;
        end
    end

    `FPMS_ASSERT_NOW(a_pos_bound, 1'b1, pos_reg <= POS_W'(MAX_PATH), "position past limit")
    `FPMS_ASSERT_NOW(a_div_rem, 1'b1, r6_reg < 3'(LEN_DIVISOR), "length divider remainder bad")
    `FPMS_ASSERT_NEXT(a_path_clear, accept && last, pos_reg == '0 && qi_reg == '0,
        "path state not cleared after last byte")

endmodule
